// ===== rtl/spf_pkg.sv =====
// shortest path finder package: field widths, command and status codes, result types
// no dependencies
package spf_pkg;

    localparam int CITY_W = 5;
    localparam int LEN_IN_W = 8;
    localparam int LEN_MAX_W = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] ST_STEP = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;

    typedef struct packed {
        logic [CITY_W-1:0] city;
        logic              last;
        logic [1:0]        status;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_push;

endpackage

// ===== rtl/spf_if.sv =====
// valid/ready channel interfaces for the input items and the result items
// depends on spf_pkg
interface spf_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [spf_pkg::CITY_W-1:0] from_city;
    logic [spf_pkg::CITY_W-1:0] to_city;
    logic [spf_pkg::LEN_IN_W-1:0] road_len;

    modport source (output valid, cmd, from_city, to_city, road_len, input ready);
    modport sink (input valid, cmd, from_city, to_city, road_len, output ready);
endinterface

interface spf_out_if;
    logic                       valid;
    logic                       ready;
    logic [spf_pkg::CITY_W-1:0] city;
    logic                       last;
    logic [1:0]                 status;

    modport source (output valid, city, last, status, input ready);
    modport sink (input valid, city, last, status, output ready);
endinterface

// ===== rtl/spf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spf_engine.sv =====
// search sequencer: road matrix, distance, predecessor and path rams, one shared
// add and compare unit stepped over cities; depends on spf_pkg and spf_ram
module spf_engine #(
    parameter int NUM_CITIES = 32,
    parameter int LEN_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic [spf_pkg::CITY_W-1:0]   i_from_city,
    input  logic [spf_pkg::CITY_W-1:0]   i_to_city,
    input  logic [spf_pkg::LEN_IN_W-1:0] i_road_len,
    input  logic                         i_space,
    output spf_pkg::t_push               o_push
);

    localparam int CW = (NUM_CITIES > 1) ? $clog2(NUM_CITIES) : 1;
    localparam int DW = LEN_BITS + CW;
    localparam int MAW = 2 * CW;
    localparam int MDEPTH = 2 ** MAW;

    localparam logic [3:0] S_CLR       = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_INIT      = 4'd2;
    localparam logic [3:0] S_SCAN      = 4'd3;
    localparam logic [3:0] S_SCAN_END  = 4'd4;
    localparam logic [3:0] S_PICK      = 4'd5;
    localparam logic [3:0] S_RELAX     = 4'd6;
    localparam logic [3:0] S_RELAX_END = 4'd7;
    localparam logic [3:0] S_CHECK     = 4'd8;
    localparam logic [3:0] S_WALK      = 4'd9;
    localparam logic [3:0] S_WALK_WT   = 4'd10;
    localparam logic [3:0] S_EMIT_RD   = 4'd11;
    localparam logic [3:0] S_EMIT_LD   = 4'd12;
    localparam logic [3:0] S_ONE       = 4'd13;

    logic [3:0]            r_state, n_state;
    logic [MAW-1:0]        r_clr, n_clr;
    logic [CW-1:0]         r_src, n_src;
    logic [CW-1:0]         r_tgt, n_tgt;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_pv, n_pv;
    logic [CW-1:0]         r_pidx, n_pidx;
    logic                  r_found, n_found;
    logic [CW-1:0]         r_best, n_best;
    logic [DW-1:0]         r_bestd, n_bestd;
    logic [NUM_CITIES-1:0] r_reached, n_reached;
    logic [NUM_CITIES-1:0] r_settled, n_settled;
    logic [CW-1:0]         r_c, n_c;
    logic [CW-1:0]         r_n, n_n;
    logic [1:0]            r_one_st, n_one_st;

    logic                  mat_we;
    logic [MAW-1:0]        mat_waddr;
    logic [LEN_BITS-1:0]   mat_wdata;
    logic [LEN_BITS-1:0]   mat_rdata;
    logic                  dist_we;
    logic [CW-1:0]         dist_waddr;
    logic [DW-1:0]         dist_wdata;
    logic [DW-1:0]         dist_rdata;
    logic                  pred_we;
    logic [CW-1:0]         pred_waddr;
    logic [CW-1:0]         pred_wdata;
    logic [CW-1:0]         pred_rdata;
    logic                  buf_we;
    logic [CW-1:0]         buf_rdata;

    logic [spf_pkg::LEN_MAX_W-1:0] len_ext;
    logic [DW-1:0]         sum;
    logic [DW-1:0]         cmp_a;
    logic [DW-1:0]         cmp_b;
    logic                  lt;
    logic                  scan_proc;
    logic                  relax_proc;
    logic                  from_ok;
    logic                  to_ok;

    spf_ram #(.WIDTH(LEN_BITS), .DEPTH(MDEPTH)) u_mat (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(mat_waddr), .i_wdata(mat_wdata),
        .i_raddr({r_best, r_cnt}), .o_rdata(mat_rdata)
    );

    spf_ram #(.WIDTH(DW), .DEPTH(NUM_CITIES)) u_dist (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_waddr), .i_wdata(dist_wdata),
        .i_raddr(r_cnt), .o_rdata(dist_rdata)
    );

    spf_ram #(.WIDTH(CW), .DEPTH(NUM_CITIES)) u_pred (
        .i_clk(i_clk), .i_we(pred_we), .i_waddr(pred_waddr), .i_wdata(pred_wdata),
        .i_raddr(r_c), .o_rdata(pred_rdata)
    );

    spf_ram #(.WIDTH(CW), .DEPTH(NUM_CITIES)) u_path (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(r_n), .i_wdata(r_c),
        .i_raddr(r_n), .o_rdata(buf_rdata)
    );

    // shared add and compare unit
    assign relax_proc = r_pv && (r_state == S_RELAX || r_state == S_RELAX_END);
    assign scan_proc = r_pv && (r_state == S_SCAN || r_state == S_SCAN_END);
    assign sum = r_bestd + DW'(mat_rdata);
    assign cmp_a = relax_proc ? sum : dist_rdata;
    assign cmp_b = relax_proc ? dist_rdata : r_bestd;
    assign lt = cmp_a < cmp_b;

    assign len_ext = spf_pkg::LEN_MAX_W'(i_road_len);
    assign from_ok = 32'(i_from_city) < NUM_CITIES;
    assign to_ok = 32'(i_to_city) < NUM_CITIES;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_src = r_src;
        n_tgt = r_tgt;
        n_cnt = r_cnt;
        n_pv = 1'b0;
        n_pidx = r_cnt;
        n_found = r_found;
        n_best = r_best;
        n_bestd = r_bestd;
        n_reached = r_reached;
        n_settled = r_settled;
        n_c = r_c;
        n_n = r_n;
        n_one_st = r_one_st;
        mat_we = 1'b0;
        mat_waddr = r_clr;
        mat_wdata = '0;
        dist_we = 1'b0;
        dist_waddr = r_pidx;
        dist_wdata = sum;
        pred_we = 1'b0;
        pred_waddr = r_pidx;
        pred_wdata = r_best;
        buf_we = 1'b0;
        o_push = '0;

        if (scan_proc && r_reached[r_pidx] && !r_settled[r_pidx] && (!r_found || lt)) begin
            n_found = 1'b1;
            n_best = r_pidx;
            n_bestd = dist_rdata;
        end
        if (relax_proc && mat_rdata != '0 && !r_settled[r_pidx]
                && (!r_reached[r_pidx] || lt)) begin
            dist_we = 1'b1;
            pred_we = 1'b1;
            n_reached[r_pidx] = 1'b1;
        end

        case (r_state)
            S_CLR: begin
                mat_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == spf_pkg::CMD_WRITE) begin
                        if (from_ok && to_ok) begin
                            mat_we = 1'b1;
                            mat_waddr = {CW'(i_from_city), CW'(i_to_city)};
                            mat_wdata = len_ext[LEN_BITS-1:0];
                        end
                    end else begin
                        n_src = CW'(i_from_city);
                        n_tgt = CW'(i_to_city);
                        if (!from_ok || !to_ok) begin
                            n_one_st = spf_pkg::ST_UNREACH;
                            n_state = S_ONE;
                        end else if (i_from_city == i_to_city) begin
                            n_one_st = spf_pkg::ST_EMPTY;
                            n_state = S_ONE;
                        end else begin
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_INIT: begin
                n_reached = '0;
                n_reached[r_src] = 1'b1;
                n_settled = '0;
                dist_we = 1'b1;
                dist_waddr = r_src;
                dist_wdata = '0;
                pred_we = 1'b1;
                pred_waddr = r_src;
                pred_wdata = r_src;
                n_cnt = '0;
                n_found = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_pv = 1'b1;
                if (r_cnt == CW'(NUM_CITIES - 1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCAN_END: begin
                n_cnt = '0;
                n_state = S_PICK;
            end
            S_PICK: begin
                if (!r_found) begin
                    n_state = S_CHECK;
                end else begin
                    n_settled[r_best] = 1'b1;
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                n_pv = 1'b1;
                if (r_cnt == CW'(NUM_CITIES - 1)) begin
                    n_state = S_RELAX_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RELAX_END: begin
                n_cnt = '0;
                n_found = 1'b0;
                n_state = S_SCAN;
            end
            S_CHECK: begin
                if (!r_reached[r_tgt]) begin
                    n_one_st = spf_pkg::ST_UNREACH;
                    n_state = S_ONE;
                end else begin
                    n_c = r_tgt;
                    n_n = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_c == r_src || r_n == CW'(NUM_CITIES - 1)) begin
                    n_n = r_n - 1'b1;
                    n_state = S_EMIT_RD;
                end else begin
                    buf_we = 1'b1;
                    n_n = r_n + 1'b1;
                    n_state = S_WALK_WT;
                end
            end
            S_WALK_WT: begin
                n_c = pred_rdata;
                n_state = S_WALK;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_push.valid = 1'b1;
                o_push.res.city = spf_pkg::CITY_W'(buf_rdata);
                o_push.res.last = (r_n == '0);
                o_push.res.status = spf_pkg::ST_STEP;
                if (i_space) begin
                    if (r_n == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_n = r_n - 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_ONE: begin
                o_push.valid = 1'b1;
                o_push.res.city = '0;
                o_push.res.last = 1'b1;
                o_push.res.status = r_one_st;
                if (i_space) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_pv <= 1'b0;
            r_found <= 1'b0;
            r_reached <= '0;
            r_settled <= '0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_pv <= n_pv;
            r_found <= n_found;
            r_reached <= n_reached;
            r_settled <= n_settled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_tgt <= n_tgt;
        r_cnt <= n_cnt;
        r_pidx <= n_pidx;
        r_best <= n_best;
        r_bestd <= n_bestd;
        r_c <= n_c;
        r_n <= n_n;
        r_one_st <= n_one_st;
    end

`ifndef SYNTHESIS
    a_settled_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settled & ~r_reached) == '0)
        else $error("settled city not reached");
    a_pick_settles_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && r_found) |=>
        ($countones(r_settled) == $countones($past(r_settled)) + 1))
        else $error("pick did not settle exactly one new city");
    a_init_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |=> (r_reached[r_src] && r_settled == '0))
        else $error("search start left source unreached");
`endif

endmodule

// ===== rtl/shortest_path_finder_top.sv =====
// shortest path finder top level: channel interfaces, search engine, output register
// depends on spf_pkg, spf_if, spf_engine
//
// channel  dir  payload                              transfer
// i_in     in   cmd, from_city, to_city, road_len    valid & ready
// o_out    out  city, last, status                   valid & ready
//
// after reset a clearing pass over all 2^(2*clog2(NUM_CITIES)) entries empties the road
// matrix (1024 for 32 cities); no item is taken meanwhile
// a road write is taken in the idle state; a query takes a start step, up to NUM_CITIES
// rounds of scan, pick and relax and a closing scan through the shared unit, then a
// walk back along the predecessors and one result per path city, each waiting for room
// in the one result register: the next item is taken while the last result waits
module shortest_path_finder_top #(
    parameter int NUM_CITIES = 32,
    parameter int LEN_BITS = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    spf_in_if.sink    i_in,
    spf_out_if.source o_out
);

    spf_pkg::t_push push;
    logic           space;
    logic           r_ovalid;
    spf_pkg::t_res  r_ores;

    assign space = !r_ovalid || o_out.ready;

    spf_engine #(.NUM_CITIES(NUM_CITIES), .LEN_BITS(LEN_BITS)) u_engine (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_cmd(i_in.cmd),
        .i_from_city(i_in.from_city),
        .i_to_city(i_in.to_city),
        .i_road_len(i_in.road_len),
        .i_space(space),
        .o_push(push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push.valid && space) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid && space) begin
            r_ores <= push.res;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.city = r_ores.city;
    assign o_out.last = r_ores.last;
    assign o_out.status = r_ores.status;

endmodule

// ===== tb/sv/tb_shortest_path_finder_top.sv =====
// testbench for the shortest path finder: directed table, a long chain, then random roads and queries
// checks every result against a local dijkstra predictor; depends on spf_pkg, spf_if, rtl
module tb_shortest_path_finder_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spf_pkg::*;

    localparam int N = 32;
    localparam int N_RAND = 420;

    typedef struct packed {
        logic                cmd;
        logic [CITY_W-1:0]   from_city;
        logic [CITY_W-1:0]   to_city;
        logic [LEN_IN_W-1:0] road_len;
    } t_item;

    typedef struct {
        t_item item;
        bit    has_exp;
        t_res  exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    spf_in_if  in_ch ();
    spf_out_if out_ch ();

    shortest_path_finder_top #(.NUM_CITIES(N), .LEN_BITS(8)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    logic [7:0]  roads [N][N];
    logic [12:0] dist_of [N];
    bit          got_to [N];
    bit          done_at [N];
    logic [4:0]  came_from [N];
    t_res        path_q [$];
    int          n_bad = 0;
    int          src_idle = 0;
    int          snk_idle = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;
    t_row        table_rows [$];

    task automatic report_bad(input string what, input t_res got, input t_res want);
        $display("mismatch %s: got city %0d last %0d status %0d, want %0d %0d %0d",
                 what, got.city, got.last, got.status, want.city, want.last, want.status);
        n_bad++;
    endtask

    function automatic t_res single_res(input logic [1:0] st);
        t_res r;
        r.city = '0;
        r.last = 1'b1;
        r.status = st;
        return r;
    endfunction

    function automatic void predict_path(input t_item it);
        int best;
        logic [4:0] c;
        logic [4:0] trail [$];
        logic [12:0] cand;
        t_res r;
        if (it.cmd == CMD_WRITE) begin
            roads[it.from_city][it.to_city] = it.road_len;
            return;
        end
        if (it.from_city == it.to_city) begin
            path_q.push_back(single_res(ST_EMPTY));
            return;
        end
        foreach (got_to[i]) begin
            got_to[i] = 1'b0;
            done_at[i] = 1'b0;
        end
        dist_of[it.from_city] = '0;
        came_from[it.from_city] = it.from_city;
        got_to[it.from_city] = 1'b1;
        for (int rnd = 0; rnd < N; rnd++) begin
            best = -1;
            for (int i = 0; i < N; i++)
                if (got_to[i] && !done_at[i] && (best < 0 || dist_of[i] < dist_of[best]))
                    best = i;
            if (best < 0) break;
            done_at[best] = 1'b1;
            for (int v = 0; v < N; v++) begin
                if (roads[best][v] == 0 || done_at[v]) continue;
                cand = dist_of[best] + roads[best][v];
                if (!got_to[v] || cand < dist_of[v]) begin
                    dist_of[v] = cand;
                    came_from[v] = best[4:0];
                    got_to[v] = 1'b1;
                end
            end
        end
        if (!got_to[it.to_city]) begin
            path_q.push_back(single_res(ST_UNREACH));
            return;
        end
        c = it.to_city;
        while (c != it.from_city && trail.size() < N - 1) begin
            trail.push_front(c);
            c = came_from[c];
        end
        foreach (trail[k]) begin
            r.city = trail[k];
            r.last = (k == trail.size() - 1);
            r.status = ST_STEP;
            path_q.push_back(r);
        end
    endfunction

    task automatic send_item(input t_item it);
        while (src_idle > 0 && $urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.cmd, in_ch.from_city, in_ch.to_city, in_ch.road_len} <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_path(it);
    endtask

    function automatic t_item mk(input logic cmd, input int a, input int b, input int l);
        t_item it;
        it.cmd = cmd;
        it.from_city = a[4:0];
        it.to_city = b[4:0];
        it.road_len = l[7:0];
        return it;
    endfunction

    function automatic t_item rand_item(input bit chain);
        t_item it;
        it.cmd = ($urandom_range(99) < 30) ? CMD_QUERY : CMD_WRITE;
        it.from_city = chain ? 5'($urandom_range(7)) : 5'($urandom);
        it.to_city = chain ? 5'($urandom_range(7)) : 5'($urandom);
        it.road_len = ($urandom_range(9) == 0) ? 8'd0 :
                      ($urandom_range(9) == 0) ? 8'hff : 8'($urandom_range(1, 40));
        return it;
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{city: out_ch.city, last: out_ch.last, status: out_ch.status};
            if (path_q.size() == 0) report_bad("unexpected", got, '0);
            else if (got !== path_q[0]) report_bad("field", got, path_q.pop_front());
            else void'(path_q.pop_front());
        end
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !hold_off && !(snk_idle > 0 && $urandom_range(99) < snk_idle);
    end

    initial begin
        int pos;
        t_item it;
        foreach (roads[i, j]) roads[i][j] = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_WRITE;
        in_ch.from_city = '0;
        in_ch.to_city = '0;
        in_ch.road_len = '0;
        out_ch.ready = 1'b0;
        table_rows = '{
            '{mk(CMD_QUERY, 0, 31, 0), 1, single_res(ST_UNREACH)},
            '{mk(CMD_QUERY, 31, 31, 0), 1, single_res(ST_EMPTY)},
            '{mk(CMD_QUERY, 0, 0, 255), 1, single_res(ST_EMPTY)},
            '{mk(CMD_WRITE, 0, 1, 255), 0, '0},
            '{mk(CMD_WRITE, 1, 31, 1), 0, '0},
            '{mk(CMD_WRITE, 5, 5, 3), 0, '0},
            '{mk(CMD_QUERY, 0, 31, 0), 0, '0},
            '{mk(CMD_QUERY, 31, 0, 0), 1, single_res(ST_UNREACH)},
            '{mk(CMD_QUERY, 5, 6, 0), 1, single_res(ST_UNREACH)},
            '{mk(CMD_WRITE, 0, 2, 100), 0, '0},
            '{mk(CMD_WRITE, 2, 31, 100), 0, '0},
            '{mk(CMD_QUERY, 0, 31, 0), 0, '0},
            '{mk(CMD_WRITE, 0, 3, 128), 0, '0},
            '{mk(CMD_WRITE, 3, 31, 128), 0, '0},
            '{mk(CMD_QUERY, 0, 31, 0), 0, '0},
            '{mk(CMD_WRITE, 0, 2, 0), 0, '0},
            '{mk(CMD_QUERY, 0, 31, 0), 0, '0},
            '{mk(CMD_QUERY, 0, 1, 0), 0, '0}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (table_rows[r]) begin
            if (table_rows[r].has_exp) begin
                send_item(table_rows[r].item);
                if (path_q.size() == 0 || path_q[path_q.size() - 1] !== table_rows[r].exp)
                    report_bad("table", path_q.size() ? path_q[$] : '0, table_rows[r].exp);
            end else begin
                send_item(table_rows[r].item);
            end
        end
        // long chain so a query yields many results
        for (int i = 0; i < 31; i++) send_item(mk(CMD_WRITE, i, i + 1, 1));
        send_item(mk(CMD_QUERY, 0, 31, 0));
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 35 : (ph == 1) ? 74 : 0;
            snk_idle = (ph == 0) ? 74 : (ph == 1) ? 35 : 0;
            pos = 0;
            while (pos < N_RAND / 3) begin
                it = rand_item($urandom_range(3) != 0);
                if (ph == 2 && pos == 20) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (4000) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                    for (int k = 0; k < 4; k++) send_item(mk(CMD_QUERY, 0, 31 - k, 0));
                end
                send_item(it);
                pos++;
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (path_q.size() != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
        if (n_bad == 0 && path_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== shortest_path_finder_top.f =====
rtl/spf_pkg.sv
rtl/spf_if.sv
rtl/spf_ram.sv
rtl/spf_engine.sv
rtl/shortest_path_finder_top.sv
tb/sv/tb_shortest_path_finder_top.sv
